// File: hw/rtl/pdmm_pkg.sv
package pdmm_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 8;
	localparam int DIST_BITS  = COORD_BITS + 1 + FRAC_BITS;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int RAD_BITS   = 2 * DIST_BITS;
	localparam int REM_BITS   = DIST_BITS + 1;
	localparam int ROOT_STEPS = DIST_BITS;
	localparam int STEP_BITS  = $clog2(ROOT_STEPS);
	localparam int CFG_BITS   = 2;

	localparam logic [1:0] MET_EUCLID    = 2'd0;
	localparam logic [1:0] MET_MANHATTAN = 2'd1;

	localparam logic [CFG_BITS-1:0] CFG_REF_ROW   = 2'd0;
	localparam logic [CFG_BITS-1:0] CFG_REF_COL   = 2'd1;
	localparam logic [CFG_BITS-1:0] CFG_ROW_LIMIT = 2'd2;
	localparam logic [CFG_BITS-1:0] CFG_COL_LIMIT = 2'd3;

	typedef enum logic [1:0] {
		RES_OK     = 2'd0,
		RES_RANGE  = 2'd1,
		RES_METRIC = 2'd2
	} res_code_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SQUARE,
		CS_SUM,
		CS_ROOT,
		CS_UPDATE
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic sum;
		logic step;
		logic update;
	} ctl_cmd_t;

	typedef struct packed {
		logic direct;
		logic out_free;
	} dp_stat_t;

endpackage

// File: hw/rtl/pdmm_ctrl.sv
module pdmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pdmm_pkg::dp_stat_t  stat,
	output pdmm_pkg::ctl_cmd_t  cmd
);

	pdmm_pkg::ctl_state_t state_q, state_d;
	logic [pdmm_pkg::STEP_BITS-1:0] step_q;
	logic root_last;

	assign root_last = (step_q == pdmm_pkg::STEP_BITS'(pdmm_pkg::ROOT_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdmm_pkg::CS_IDLE: begin
				if (in_valid) state_d = pdmm_pkg::CS_SQUARE;
			end
			pdmm_pkg::CS_SQUARE: begin
				state_d = stat.direct ? pdmm_pkg::CS_UPDATE : pdmm_pkg::CS_SUM;
			end
			pdmm_pkg::CS_SUM: begin
				state_d = pdmm_pkg::CS_ROOT;
			end
			pdmm_pkg::CS_ROOT: begin
				if (root_last) state_d = pdmm_pkg::CS_UPDATE;
			end
			pdmm_pkg::CS_UPDATE: begin
				if (stat.out_free) state_d = pdmm_pkg::CS_IDLE;
			end
			default: state_d = pdmm_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != pdmm_pkg::CS_IDLE);
		cmd.load   = (state_q == pdmm_pkg::CS_IDLE) && in_valid;
		cmd.square = (state_q == pdmm_pkg::CS_SQUARE);
		cmd.sum    = (state_q == pdmm_pkg::CS_SUM);
		cmd.step   = (state_q == pdmm_pkg::CS_ROOT);
		cmd.update = (state_q == pdmm_pkg::CS_UPDATE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdmm_pkg::CS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pdmm_pkg::CS_SUM) begin
				step_q <= '0;
			end else if (state_q == pdmm_pkg::CS_ROOT) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	a_root_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pdmm_pkg::CS_ROOT && root_last) |=> state_q == pdmm_pkg::CS_UPDATE)
		else $error("root iteration did not end in update");

	a_sum_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum |=> (state_q == pdmm_pkg::CS_ROOT && step_q == '0))
		else $error("root iteration started without cleared step count");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("input not held off after accepting a transaction");

endmodule

// File: hw/rtl/pdmm_datapath.sv
module pdmm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pdmm_pkg::CFG_BITS-1:0]       cfg_index,
	input  logic [pdmm_pkg::COORD_BITS-1:0]     cfg_data,
	input  logic [pdmm_pkg::COORD_BITS-1:0]     point_row,
	input  logic [pdmm_pkg::COORD_BITS-1:0]     point_col,
	input  logic [1:0]                          metric,
	input  pdmm_pkg::ctl_cmd_t                  cmd,
	output pdmm_pkg::dp_stat_t                  stat,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pdmm_pkg::DIST_BITS-1:0]      distance,
	output logic [pdmm_pkg::DIST_BITS-1:0]      max_distance,
	output logic [pdmm_pkg::DIST_BITS-1:0]      min_distance,
	output logic [1:0]                          status
);

	logic [pdmm_pkg::COORD_BITS-1:0] ref_row_q, ref_col_q, row_limit_q, col_limit_q;
	logic [pdmm_pkg::COORD_BITS-1:0] dr_q, dc_q, dr_d, dc_d;
	logic                            manhattan_q;
	pdmm_pkg::res_code_t             code_q, code_d;
	logic [pdmm_pkg::SQ_BITS-1:0]    sqr_q, sqc_q;
	logic [pdmm_pkg::RAD_BITS-1:0]   rad_q;
	logic [pdmm_pkg::REM_BITS-1:0]   rem_q;
	logic [pdmm_pkg::DIST_BITS-1:0]  root_q;
	logic [pdmm_pkg::REM_BITS+1:0]   rem_t, trial;
	logic [pdmm_pkg::SUM_BITS-1:0]   sum_sq;
	logic [pdmm_pkg::DIST_BITS-1:0]  manh, dist_d;
	logic [pdmm_pkg::DIST_BITS-1:0]  max_q, min_q, max_d, min_d;
	logic                            out_valid_q;
	logic [pdmm_pkg::DIST_BITS-1:0]  dist_out_q, max_out_q, min_out_q;
	pdmm_pkg::res_code_t             code_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_row_q   <= '0;
			ref_col_q   <= '0;
			row_limit_q <= '1;
			col_limit_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdmm_pkg::CFG_REF_ROW:   ref_row_q   <= cfg_data;
				pdmm_pkg::CFG_REF_COL:   ref_col_q   <= cfg_data;
				pdmm_pkg::CFG_ROW_LIMIT: row_limit_q <= cfg_data;
				pdmm_pkg::CFG_COL_LIMIT: col_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		dr_d = (point_row >= ref_row_q) ? point_row - ref_row_q : ref_row_q - point_row;
		dc_d = (point_col >= ref_col_q) ? point_col - ref_col_q : ref_col_q - point_col;
		priority if (point_row > row_limit_q || point_col > col_limit_q) begin
			code_d = pdmm_pkg::RES_RANGE;
		end else if (metric != pdmm_pkg::MET_EUCLID && metric != pdmm_pkg::MET_MANHATTAN) begin
			code_d = pdmm_pkg::RES_METRIC;
		end else begin
			code_d = pdmm_pkg::RES_OK;
		end
	end

	assign sum_sq = pdmm_pkg::SUM_BITS'(sqr_q) + pdmm_pkg::SUM_BITS'(sqc_q);
	assign rem_t  = {rem_q, rad_q[pdmm_pkg::RAD_BITS-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign manh   = pdmm_pkg::DIST_BITS'(({1'b0, dr_q} + {1'b0, dc_q})) << pdmm_pkg::FRAC_BITS;

	always_comb begin
		if (code_q != pdmm_pkg::RES_OK) begin
			dist_d = '0;
		end else if (manhattan_q) begin
			dist_d = manh;
		end else begin
			dist_d = root_q;
		end
		max_d = max_q;
		min_d = min_q;
		if (code_q == pdmm_pkg::RES_OK) begin
			if (dist_d > max_q) max_d = dist_d;
			if (dist_d < min_q) min_d = dist_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dr_q        <= dr_d;
			dc_q        <= dc_d;
			code_q      <= code_d;
			manhattan_q <= (metric == pdmm_pkg::MET_MANHATTAN);
		end
		if (cmd.square) begin
			sqr_q <= dr_q * dr_q;
			sqc_q <= dc_q * dc_q;
		end
		if (cmd.sum) begin
			rad_q  <= pdmm_pkg::RAD_BITS'(sum_sq) << (2 * pdmm_pkg::FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.step) begin
			rad_q <= rad_q << 2;
			if (rem_t >= trial) begin
				rem_q  <= pdmm_pkg::REM_BITS'(rem_t - trial);
				root_q <= {root_q[pdmm_pkg::DIST_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= pdmm_pkg::REM_BITS'(rem_t);
				root_q <= {root_q[pdmm_pkg::DIST_BITS-2:0], 1'b0};
			end
		end
		if (cmd.update) begin
			dist_out_q <= dist_d;
			max_out_q  <= max_d;
			min_out_q  <= min_d;
			code_out_q <= code_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= '0;
			min_q       <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				max_q       <= max_d;
				min_q       <= min_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.direct   = (code_q != pdmm_pkg::RES_OK) || manhattan_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign distance     = dist_out_q;
	assign max_distance = max_out_q;
	assign min_distance = min_out_q;
	assign status       = code_out_q;

	a_ok_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && code_out_q == pdmm_pkg::RES_OK) |->
			(max_out_q >= dist_out_q && min_out_q <= dist_out_q))
		else $error("running max or min does not bound the distance");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && code_out_q != pdmm_pkg::RES_OK) |-> dist_out_q == '0)
		else $error("flagged transaction carries a distance");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

endmodule

// File: hw/rtl/point_distance_min_max_core.sv
// Distance from a grid point to a reference point, with running max and min.
// Input channel: in_valid / in_stall with point_row, point_col and metric
// (0 Euclidean, 1 Manhattan). Output channel: out_valid / out_stall with
// distance, max_distance, min_distance (8 fraction bits) and status
// (0 ok, 1 point out of range, 2 invalid metric; flagged items leave the
// running max and min alone and report distance 0).
// Configuration: cfg_we with cfg_index 0 ref_row, 1 ref_col, 2 row_limit,
// 3 col_limit; write only while no transaction is in flight.
// A Euclidean item passes through square, sum, 19 steps of the bit-serial
// square-root loop (one result bit each) and update; Manhattan and flagged
// items go from square straight to update. One item is in flight at a time
// and the controller returns to idle between items, so a new item is
// accepted only after the last one has left update.
// The output register holds one result: the next item is accepted while it
// waits, and that item stalls in its update cycle until out_stall drops.
// Reset clears the reference to 0, the limits to 1023, the running max to
// 0 and the running min to all ones (no valid distance yet).
module point_distance_min_max_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pdmm_pkg::CFG_BITS-1:0]       cfg_index,
	input  logic [pdmm_pkg::COORD_BITS-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pdmm_pkg::COORD_BITS-1:0]     point_row,
	input  logic [pdmm_pkg::COORD_BITS-1:0]     point_col,
	input  logic [1:0]                          metric,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pdmm_pkg::DIST_BITS-1:0]      distance,
	output logic [pdmm_pkg::DIST_BITS-1:0]      max_distance,
	output logic [pdmm_pkg::DIST_BITS-1:0]      min_distance,
	output logic [1:0]                          status
);

	pdmm_pkg::ctl_cmd_t cmd;
	pdmm_pkg::dp_stat_t stat;

	pdmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pdmm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.point_row    (point_row),
		.point_col    (point_col),
		.metric       (metric),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance     (distance),
		.max_distance (max_distance),
		.min_distance (min_distance),
		.status       (status)
	);

endmodule

// File: verif/point_distance_min_max_core_tb.sv
module point_distance_min_max_core_tb;

	typedef logic [pdmm_pkg::COORD_BITS-1:0] coord_t;
	typedef logic [pdmm_pkg::DIST_BITS-1:0]  dist_t;

	localparam logic [1:0] MET_BAD_LO  = 2'd2;
	localparam logic [1:0] MET_BAD_HI  = 2'd3;
	localparam dist_t      NO_MIN      = '1;
	localparam coord_t     COORD_MAX   = '1;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         TAIL_CYCLES = 30;

	typedef struct packed {
		dist_t      span;
		dist_t      far;
		dist_t      near;
		logic [1:0] code;
	} dist_result_t;

	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              cfg_we    = 1'b0;
	logic [pdmm_pkg::CFG_BITS-1:0]     cfg_index = '0;
	coord_t                            cfg_data  = '0;
	logic                              in_valid  = 1'b0;
	logic                              in_stall;
	coord_t                            point_row = '0;
	coord_t                            point_col = '0;
	logic [1:0]                        metric    = pdmm_pkg::MET_EUCLID;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	dist_t                             distance;
	dist_t                             max_distance;
	dist_t                             min_distance;
	logic [1:0]                        status;

	dist_result_t pending_results[$];
	dist_result_t oldest;
	coord_t       ref_r, ref_c, lim_r, lim_c;
	dist_t        far_seen, near_seen;
	bit           noise_on;
	int           errors, cycles, settings, stall_left;
	int           n_euclid, n_manhattan, n_range, n_metric;

	point_distance_min_max_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_row    (point_row),
		.point_col    (point_col),
		.metric       (metric),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance     (distance),
		.max_distance (max_distance),
		.min_distance (min_distance),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dist_t int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] weight;
		logic [63:0] rem;
		root   = '0;
		weight = 64'h1 << 62;
		rem    = v;
		while (weight > rem)
			weight >>= 2;
		while (weight != 0) begin
			if (rem >= root + weight) begin
				rem  -= root + weight;
				root  = (root >> 1) + weight;
			end else begin
				root >>= 1;
			end
			weight >>= 2;
		end
		return root[pdmm_pkg::DIST_BITS-1:0];
	endfunction

	function automatic dist_result_t predict_point(input coord_t row, col,
			input logic [1:0] met);
		dist_result_t r;
		logic [63:0]  dr, dc, d;
		r = '0;
		d = '0;
		if (row > lim_r || col > lim_c) begin
			r.code = pdmm_pkg::RES_RANGE;
			n_range++;
		end else if (met != pdmm_pkg::MET_EUCLID && met != pdmm_pkg::MET_MANHATTAN) begin
			r.code = pdmm_pkg::RES_METRIC;
			n_metric++;
		end else begin
			dr = (row >= ref_r) ? row - ref_r : ref_r - row;
			dc = (col >= ref_c) ? col - ref_c : ref_c - col;
			if (met == pdmm_pkg::MET_EUCLID) begin
				d = int_sqrt((dr * dr + dc * dc) << (2 * pdmm_pkg::FRAC_BITS));
				n_euclid++;
			end else begin
				d = (dr + dc) << pdmm_pkg::FRAC_BITS;
				n_manhattan++;
			end
			if (d[pdmm_pkg::DIST_BITS-1:0] > far_seen)
				far_seen = d[pdmm_pkg::DIST_BITS-1:0];
			if (d[pdmm_pkg::DIST_BITS-1:0] < near_seen)
				near_seen = d[pdmm_pkg::DIST_BITS-1:0];
			r.code = pdmm_pkg::RES_OK;
			r.span = d[pdmm_pkg::DIST_BITS-1:0];
		end
		r.far  = far_seen;
		r.near = near_seen;
		return r;
	endfunction

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return COORD_MAX;
			default: return coord_t'($urandom_range(0, COORD_MAX));
		endcase
	endfunction

	task automatic check_field(input string name, input dist_t want, got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic send_point(input coord_t row, col, input logic [1:0] met);
		if (noise_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		point_row <= row;
		point_col <= col;
		metric    <= met;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_point(row, col, met));
	endtask

	task automatic send_random_point();
		coord_t     row, col;
		logic [1:0] met;
		int         k;
		if ($urandom_range(0, 4) != 0) begin
			row = coord_t'($urandom_range(0, lim_r));
			col = coord_t'($urandom_range(0, lim_c));
		end else begin
			row = coord_t'($urandom_range(0, COORD_MAX));
			col = coord_t'($urandom_range(0, COORD_MAX));
		end
		k = $urandom_range(0, 9);
		if (k < 4)
			met = pdmm_pkg::MET_EUCLID;
		else if (k < 8)
			met = pdmm_pkg::MET_MANHATTAN;
		else
			met = (k == 8) ? MET_BAD_LO : MET_BAD_HI;
		send_point(row, col, met);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apply_setting(input coord_t rr, rc, rl, cl);
		cfg_we    <= 1'b1;
		cfg_index <= pdmm_pkg::CFG_REF_ROW;
		cfg_data  <= rr;
		@(posedge clk);
		cfg_index <= pdmm_pkg::CFG_REF_COL;
		cfg_data  <= rc;
		@(posedge clk);
		cfg_index <= pdmm_pkg::CFG_ROW_LIMIT;
		cfg_data  <= rl;
		@(posedge clk);
		cfg_index <= pdmm_pkg::CFG_COL_LIMIT;
		cfg_data  <= cl;
		@(posedge clk);
		cfg_we <= 1'b0;
		ref_r  = rr;
		ref_c  = rc;
		lim_r  = rl;
		lim_c  = cl;
		settings++;
	endtask

	task automatic test_reset_defaults();
		send_point(5, 7, MET_BAD_LO);
		send_point(COORD_MAX, COORD_MAX, MET_BAD_HI);
		send_point(0, 0, pdmm_pkg::MET_MANHATTAN);
		send_point(3, 4, pdmm_pkg::MET_EUCLID);
		send_point(COORD_MAX, COORD_MAX, pdmm_pkg::MET_EUCLID);
		send_point(COORD_MAX, COORD_MAX, pdmm_pkg::MET_MANHATTAN);
		send_point(1, 1, pdmm_pkg::MET_EUCLID);
	endtask

	task automatic test_range_edges();
		settle();
		apply_setting(512, 300, 600, 700);
		send_point(600, 700, pdmm_pkg::MET_EUCLID);
		send_point(601, 700, pdmm_pkg::MET_MANHATTAN);
		send_point(600, 701, pdmm_pkg::MET_MANHATTAN);
		send_point(COORD_MAX, COORD_MAX, pdmm_pkg::MET_EUCLID);
		send_point(601, 0, MET_BAD_LO);
		send_point(0, 0, pdmm_pkg::MET_MANHATTAN);
		send_point(600, 0, MET_BAD_HI);
	endtask

	task automatic test_zero_limits();
		settle();
		apply_setting(COORD_MAX, COORD_MAX, 0, 0);
		send_point(0, 0, pdmm_pkg::MET_EUCLID);
		send_point(0, 0, pdmm_pkg::MET_MANHATTAN);
		send_point(0, 1, pdmm_pkg::MET_EUCLID);
		send_point(1, 0, pdmm_pkg::MET_EUCLID);
		send_point(0, 0, MET_BAD_LO);
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 9; phase++) begin
			settle();
			apply_setting(pick_coord(), pick_coord(), pick_coord(), pick_coord());
			repeat (100) send_random_point();
		end
	endtask

	task automatic test_quiet_tail();
		settle();
		apply_setting(pick_coord(), pick_coord(), COORD_MAX, COORD_MAX);
		noise_on = 1'b0;
		repeat (100) send_random_point();
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[point_distance_min_max_core] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got distance %0d status %0d",
					$time, distance, status);
				errors++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("distance", oldest.span, distance);
				check_field("max_distance", oldest.far, max_distance);
				check_field("min_distance", oldest.near, min_distance);
				check_field("status", dist_t'(oldest.code), dist_t'(status));
			end
		end
		if (noise_on && stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = $urandom_range(1, 7);
		if (noise_on && stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end
	end

	initial begin
		ref_r     = '0;
		ref_c     = '0;
		lim_r     = COORD_MAX;
		lim_c     = COORD_MAX;
		far_seen  = '0;
		near_seen = NO_MIN;
		noise_on  = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_range_edges();
		test_zero_limits();
		test_random_settings();
		test_quiet_tail();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d Euclidean, %0d Manhattan, %0d out-of-range, %0d bad-metric points",
			n_euclid, n_manhattan, n_range, n_metric);
		$display("across %0d register settings, with and without idling on both sides", settings);
		if (errors == 0)
			$display("[point_distance_min_max_core] OK");
		else
			$display("[point_distance_min_max_core] ERROR");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pdmm_pkg.sv
hw/rtl/pdmm_ctrl.sv
hw/rtl/pdmm_datapath.sv
hw/rtl/point_distance_min_max_core.sv
verif/point_distance_min_max_core_tb.sv
